>>> rtl/core/nearest_marker_distance_top_defines.svh
// assertion macros shared by the nearest marker distance modules
`ifndef NEAREST_MARKER_DISTANCE_TOP_DEFINES_SVH
`define NEAREST_MARKER_DISTANCE_TOP_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define NMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk outside reset
`define NMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/nmd_pkg.sv
// shared constants and controller/datapath types for the nearest marker distance block
package nmd_pkg;

  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int DIST_W  = 7;
  localparam int CHAR_W  = 8;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  localparam logic [DIST_W-1:0] NO_MARK   = 7'd127;
  localparam logic [DIST_W-1:0] SINCE_MAX = 7'd126;

  localparam logic [PADDR_W-3:0] REG_MARKER = 1'b0;

  typedef struct packed {
    logic accept;
    logic back_rd;
    logic back_wr;
    logic emit_rd;
    logic emit_ld;
  } nmd_cmd_t;

  typedef struct packed {
    logic idx_zero;
    logic idx_final;
    logic out_free;
  } nmd_sts_t;

endpackage

>>> rtl/core/nmd_ram.sv
// generic single-write, single-read ram with registered read data
module nmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/nmd_regs.sv
// apb configuration register holding the marker character
module nmd_regs
  import nmd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output logic [CHAR_W-1:0]  marker_char
);

  logic hit;

  assign hit    = (paddr[PADDR_W-1:2] == REG_MARKER);
  assign pready = 1'b1;
  assign prdata = hit ? DATA_W'(marker_char) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_char <= '0;
    end else if (psel && penable && pwrite && pready && hit) begin
      marker_char <= pwdata[CHAR_W-1:0];
    end
  end

endmodule

>>> rtl/core/nmd_ctrl.sv
// controller state machine: load, backward pass and emission sequencing
`include "nearest_marker_distance_top_defines.svh"

module nmd_ctrl
  import nmd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     char_valid,
  input  logic     is_last,
  output logic     char_stall,
  output nmd_cmd_t cmd,
  input  nmd_sts_t sts
);

  typedef enum logic [4:0] {
    ST_LOAD    = 5'b00001,
    ST_BACK_RD = 5'b00010,
    ST_BACK_WR = 5'b00100,
    ST_EMIT_RD = 5'b01000,
    ST_EMIT_LD = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign char_stall  = (state != ST_LOAD);
  assign cmd.accept  = (state == ST_LOAD) && char_valid;
  assign cmd.back_rd = (state == ST_BACK_RD);
  assign cmd.back_wr = (state == ST_BACK_WR);
  assign cmd.emit_rd = (state == ST_EMIT_RD);
  assign cmd.emit_ld = (state == ST_EMIT_LD) && sts.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (char_valid && is_last) begin
          state_next = ST_BACK_RD;
        end
      end
      ST_BACK_RD: begin
        state_next = ST_BACK_WR;
      end
      ST_BACK_WR: begin
        state_next = sts.idx_zero ? ST_EMIT_RD : ST_BACK_RD;
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (sts.out_free) begin
          state_next = sts.idx_final ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  `NMD_ASSERT_NEXT(a_last_starts_pass, cmd.accept && is_last, state == ST_BACK_RD, "final transaction did not start backward pass")
  `NMD_ASSERT_NEXT(a_pass_ends_at_zero, cmd.back_wr && sts.idx_zero, state == ST_EMIT_RD, "backward pass did not hand over to emission")
  `NMD_ASSERT_NEXT(a_emit_holds, (state == ST_EMIT_LD) && !sts.out_free, state == ST_EMIT_LD, "emission left while output busy")

endmodule

>>> rtl/core/nmd_datapath.sv
// datapath: left distance tracking, line store, backward minimum and result register
`include "nearest_marker_distance_top_defines.svh"

module nmd_datapath
  import nmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  nmd_cmd_t          cmd,
  output nmd_sts_t          sts,
  input  logic [CHAR_W-1:0] marker_char,
  input  logic [CHAR_W-1:0] char_in,
  input  logic              is_last,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [DIST_W-1:0] distance,
  output logic              last_result,
  output logic              overflow
);

  logic [CNT_W-1:0]  stored_count;
  logic [DIST_W-1:0] since_marker;
  logic              marker_seen;
  logic              overflow_flag;
  logic [ADDR_W-1:0] idx;
  logic [DIST_W-1:0] right_dist;
  logic              right_seen;

  logic              has_room;
  logic              is_mark;
  logic              seen_next;
  logic [DIST_W-1:0] since_next;
  logic [CNT_W-1:0]  count_next;
  logic [DIST_W-1:0] left_val;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DIST_W-1:0] ram_wdata;
  logic              ram_re;
  logic [DIST_W-1:0] ram_rdata;

  logic              right_seen_next;
  logic [DIST_W-1:0] right_next;
  logic [DIST_W-1:0] dist_val;

  // forward side
  assign has_room   = (stored_count < CNT_W'(MAX_LEN));
  assign is_mark    = (char_in == marker_char);
  assign seen_next  = marker_seen || is_mark;
  assign count_next = has_room ? stored_count + CNT_W'(1) : stored_count;

  always_comb begin
    since_next = since_marker;
    if (is_mark) begin
      since_next = '0;
    end else if (marker_seen && (since_marker < SINCE_MAX)) begin
      since_next = since_marker + DIST_W'(1);
    end
  end

  assign left_val = seen_next ? since_next : NO_MARK;

  // backward side
  always_comb begin
    right_seen_next = right_seen;
    right_next      = right_dist;
    if (ram_rdata == '0) begin
      right_seen_next = 1'b1;
      right_next      = '0;
    end else if (right_seen) begin
      right_next = right_dist + DIST_W'(1);
    end
  end

  always_comb begin
    if (!right_seen_next && (ram_rdata == NO_MARK)) begin
      dist_val = DIST_W'(idx) + DIST_W'(1);
    end else if (!right_seen_next) begin
      dist_val = ram_rdata;
    end else if ((ram_rdata == NO_MARK) || (right_next < ram_rdata)) begin
      dist_val = right_next;
    end else begin
      dist_val = ram_rdata;
    end
  end

  // line store, shared by the left distances and the final results
  assign ram_we    = (cmd.accept && has_room) || cmd.back_wr;
  assign ram_waddr = cmd.back_wr ? idx : stored_count[ADDR_W-1:0];
  assign ram_wdata = cmd.back_wr ? dist_val : left_val;
  assign ram_re    = cmd.back_rd || cmd.emit_rd;

  nmd_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_LEN)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign sts.idx_zero  = (idx == '0);
  assign sts.idx_final = (idx == ADDR_W'(stored_count - CNT_W'(1)));
  assign sts.out_free  = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count  <= '0;
      since_marker  <= '0;
      marker_seen   <= 1'b0;
      overflow_flag <= 1'b0;
    end else if (cmd.accept) begin
      if (has_room) begin
        since_marker <= since_next;
        marker_seen  <= seen_next;
        stored_count <= count_next;
      end else begin
        overflow_flag <= 1'b1;
      end
    end else if (cmd.emit_ld && sts.idx_final) begin
      stored_count  <= '0;
      since_marker  <= '0;
      marker_seen   <= 1'b0;
      overflow_flag <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_last) begin
      idx        <= ADDR_W'(count_next - CNT_W'(1));
      right_dist <= '0;
      right_seen <= 1'b0;
    end else if (cmd.back_wr) begin
      right_dist <= right_next;
      right_seen <= right_seen_next;
      if (idx != '0) begin
        idx <= idx - ADDR_W'(1);
      end
    end else if (cmd.emit_ld && !sts.idx_final) begin
      idx <= idx + ADDR_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_ld) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      distance    <= ram_rdata;
      last_result <= sts.idx_final;
      overflow    <= overflow_flag;
    end
  end

  `NMD_ASSERT_NOW(a_count_bound, 1'b1, stored_count <= CNT_W'(MAX_LEN), "stored count beyond line length")
  `NMD_ASSERT_NEXT(a_clear_after_final, cmd.emit_ld && sts.idx_final, stored_count == '0 && !overflow_flag && !marker_seen, "string state not cleared after final result")
  `NMD_ASSERT_NEXT(a_load_shows_result, cmd.emit_ld, result_valid, "loaded result not presented")

endmodule

>>> rtl/core/nearest_marker_distance_top.sv
// Nearest marker distance, top level. Characters are taken one per cycle while the block
// is loading; each one writes its left-side distance into a MAX_LEN-entry line store.
// After the final character (is_last) the block stops taking characters, runs a backward
// pass with one read and one write-back on the line store per stored position (its read
// data is registered), then emits one result per stored position from position 0 upward
// while result_stall stays low. The next string is accepted as soon as the last result
// sits in the output register. Characters beyond MAX_LEN are dropped and flag every result
// of that string with overflow. The marker character sits at byte address 0 of the
// configuration port and is to be written by the user only while the block is idle; the
// block itself does not enforce this.
module nearest_marker_distance_top
  import nmd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [CHAR_W-1:0]  char_in,
  input  logic               is_last,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [DIST_W-1:0]  distance,
  output logic               last_result,
  output logic               overflow
);

  logic [CHAR_W-1:0] marker_char;
  nmd_cmd_t          cmd;
  nmd_sts_t          sts;

  nmd_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .marker_char (marker_char)
  );

  nmd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .is_last    (is_last),
    .char_stall (char_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  nmd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .marker_char  (marker_char),
    .char_in      (char_in),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .distance     (distance),
    .last_result  (last_result),
    .overflow     (overflow)
  );

endmodule
